// ===== rtl/core/pcos_pkg.sv =====
// ----------------------------------------------------------------------------
// pcos_pkg
// shared widths, register indexes and lane control type for the phase
// current offset calibration and scaling block
// ----------------------------------------------------------------------------
package pcos_pkg;

  localparam int RAW_W     = 12;  // adc sample width
  localparam int GAIN_W    = 16;  // q0.16 gain width
  localparam int SUM_W     = 22;  // per-phase accumulator, holds 4095 * 1024
  localparam int CUR_W     = 29;  // signed scaled current
  localparam int VOLT_W    = 28;  // unsigned scaled bus voltage
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam int SAMPLES_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = CFG_IDX_W'(1);

  typedef logic signed [CUR_W-1:0] cur_t;

  // control broadcast from the sequencer to every lane
  typedef struct packed {
    logic acc;       // add the lane sample into the sum
    logic div_step;  // latch the offset from the finished sum
  } lane_ctrl_t;

endpackage

// ===== rtl/core/pcos_lane.sv =====
// ----------------------------------------------------------------------------
// pcos_lane
// one phase: sample accumulator, reciprocal offset divide and
// offset-corrected gain multiply
// ----------------------------------------------------------------------------
module pcos_lane #(
  parameter int SAMPLES = pcos_pkg::SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcos_pkg::lane_ctrl_t         ctrl,
  input  logic [pcos_pkg::RAW_W-1:0]   raw,
  input  logic [pcos_pkg::GAIN_W-1:0]  gain,
  output pcos_pkg::cur_t               current
);
  import pcos_pkg::*;

  // sum / SAMPLES as a multiply by a rounded-up reciprocal, exact for
  // every sum that fits the accumulator
  localparam int     DIV_SH  = SUM_W + $clog2(SAMPLES);
  localparam int     RECIP_W = SUM_W + 1;
  localparam int     PROD_W  = SUM_W + RECIP_W;
  localparam longint DIV_M   =
    ((longint'(1) << DIV_SH) + longint'(SAMPLES) - longint'(1)) / longint'(SAMPLES);

  logic [SUM_W-1:0]  sum_r;
  logic [RAW_W-1:0]  offset_r;
  logic [PROD_W-1:0] recip_prod;

  logic signed [RAW_W:0]          diff;
  logic signed [GAIN_W:0]         gain_s;
  logic signed [RAW_W+GAIN_W+1:0] prod;

  assign recip_prod = PROD_W'(sum_r) * PROD_W'(DIV_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.acc) begin
      sum_r <= sum_r + SUM_W'(raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (ctrl.div_step) begin
      offset_r <= recip_prod[DIV_SH +: RAW_W];
    end
  end

  assign diff    = $signed({1'b0, raw}) - $signed({1'b0, offset_r});
  assign gain_s  = $signed({1'b0, gain});
  assign prod    = diff * gain_s;
  assign current = prod[CUR_W-1:0];

endmodule

// ===== rtl/core/pcos_merge.sv =====
// ----------------------------------------------------------------------------
// pcos_merge
// output register: gathers the lane currents and the scaled bus voltage
// into one result transfer
// ----------------------------------------------------------------------------
module pcos_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  pcos_pkg::cur_t               lane_cur [3],
  input  logic [pcos_pkg::RAW_W-1:0]   raw_volt,
  input  logic [pcos_pkg::GAIN_W-1:0]  volt_gain,
  output logic                         can_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_a,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_b,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_c,
  output logic [pcos_pkg::VOLT_W-1:0]  out_bus_voltage
);
  import pcos_pkg::*;

  logic              valid_r;
  cur_t              cur_a_r, cur_b_r, cur_c_r;
  logic [VOLT_W-1:0] volt_r;
  logic [VOLT_W-1:0] volt_prod;

  assign volt_prod = VOLT_W'(raw_volt) * VOLT_W'(volt_gain);
  assign can_take  = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_a_r <= lane_cur[0];
      cur_b_r <= lane_cur[1];
      cur_c_r <= lane_cur[2];
      volt_r  <= volt_prod;
    end
  end

  assign out_valid       = valid_r;
  assign out_current_a   = cur_a_r;
  assign out_current_b   = cur_b_r;
  assign out_current_c   = cur_c_r;
  assign out_bus_voltage = volt_r;

endmodule

// ===== rtl/core/phase_current_offset_cal_scale.sv =====
// ----------------------------------------------------------------------------
// phase_current_offset_cal_scale
// adc frame offset calibration and gain scaling, three current lanes
// ----------------------------------------------------------------------------
// output: a scaled frame is registered onto out_* in the cycle after its transfer
// throughput: one frame per cycle once calibrated while out_ready stays high, set by
//   the combinational multiply of each lane feeding the output register
// calibration: the first SAMPLES frames are absorbed one per cycle, then
//   in_ready drops in ST_DIV while every lane latches its offset
// reset: synchronous, active low; sums, offsets, gains cleared, calibration restarts
// ----------------------------------------------------------------------------
module phase_current_offset_cal_scale #(
  parameter int SAMPLES = pcos_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [pcos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcos_pkg::CFG_W-1:0]      cfg_wdata,
  // adc frame channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcos_pkg::RAW_W-1:0]      in_raw_phase_a,
  input  logic [pcos_pkg::RAW_W-1:0]      in_raw_phase_b,
  input  logic [pcos_pkg::RAW_W-1:0]      in_raw_phase_c,
  input  logic [pcos_pkg::RAW_W-1:0]      in_raw_bus_voltage,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_a,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_b,
  output logic signed [pcos_pkg::CUR_W-1:0] out_current_c,
  output logic [pcos_pkg::VOLT_W-1:0]     out_bus_voltage
);
  import pcos_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);

  typedef enum logic [1:0] {
    ST_CAL,  // accumulating calibration frames
    ST_DIV,  // latching offsets, input stalled
    ST_RUN   // scaling every frame
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [GAIN_W-1:0]    cur_gain_r;
  logic [GAIN_W-1:0]    volt_gain_r;

  logic       xfer;
  logic       can_take;
  lane_ctrl_t ctrl;
  cur_t       lane_cur [3];
  logic [RAW_W-1:0] lane_raw [3];

  // gain registers, writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_gain_r  <= '0;
      volt_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURRENT_GAIN: cur_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_VOLTAGE_GAIN: volt_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // the output register frees up in the same cycle it is drained
  assign in_ready = (state_r != ST_DIV) && can_take;
  assign xfer     = in_valid && in_ready;

  // calibration sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CAL;
      count_r <= '0;
    end else begin
      unique case (state_r)
        ST_CAL: begin
          if (xfer) begin
            count_r <= count_r + CNT_W'(1);
            if (count_r == CNT_W'(SAMPLES - 1)) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          state_r <= ST_RUN;
        end
        ST_RUN: ;
        default: state_r <= ST_CAL;
      endcase
    end
  end

  assign ctrl.acc      = xfer && (state_r == ST_CAL);
  assign ctrl.div_step = (state_r == ST_DIV);

  assign lane_raw[0] = in_raw_phase_a;
  assign lane_raw[1] = in_raw_phase_b;
  assign lane_raw[2] = in_raw_phase_c;

  // one lane per phase current
  for (genvar g = 0; g < 3; g++) begin : g_lane
    pcos_lane #(
      .SAMPLES (SAMPLES)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .raw     (lane_raw[g]),
      .gain    (cur_gain_r),
      .current (lane_cur[g])
    );
  end

  // scaled frames only; calibration frames produce no transfer
  pcos_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (xfer && (state_r == ST_RUN)),
    .lane_cur        (lane_cur),
    .raw_volt        (in_raw_bus_voltage),
    .volt_gain       (volt_gain_r),
    .can_take        (can_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_current_a   (out_current_a),
    .out_current_b   (out_current_b),
    .out_current_c   (out_current_c),
    .out_bus_voltage (out_bus_voltage)
  );

endmodule
